// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the menu controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/tbmc_pkg.sv =====
// Types, constants and helper functions of the three-button menu controller.
package tbmc_pkg;

    localparam int MAX_IR     = 16;
    localparam int TIMER_BITS = 16;
    localparam int CFG_WIDTH  = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [TIMER_BITS-1:0] TIMER_TOP = {TIMER_BITS{1'b1}};
    localparam logic [6:0] VOL_STEP = 7'd5;
    localparam logic [6:0] VOL_MAX  = 7'd100;

    // Menu pages
    typedef enum logic [1:0] {
        PAGE_MAIN   = 2'd0,
        PAGE_VOLUME = 2'd1,
        PAGE_IR     = 2'd2
    } page_t;

    // Selectable items
    localparam logic [2:0] SEL_AMP    = 3'd0;
    localparam logic [2:0] SEL_CAB    = 3'd1;
    localparam logic [2:0] SEL_REVERB = 3'd2;
    localparam logic [2:0] SEL_VOLUME = 3'd3;
    localparam logic [2:0] SEL_IR     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETURN_HOLD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_BLINK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BLINK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IR_TOTAL        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_IR      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BYPASS  = 3'd6;

    typedef struct packed {
        logic button_one;
        logic button_two;
        logic button_three;
    } in_t;

    typedef struct packed {
        logic [1:0] menu_page;
        logic [2:0] selected_item;
        logic [6:0] volume_percent;
        logic [3:0] ir_index;
        logic       ir_changed;
        logic       amp_bypass;
        logic       cab_bypass;
        logic       reverb_bypass;
        logic       led_lit;
        logic       redraw;
    } out_t;

    // x mod n for a 5-bit x and 1 <= n <= MAX_IR, by five compare-subtract steps
    function automatic logic [3:0] ir_mod(input logic [4:0] x, input logic [4:0] n);
        logic [9:0] r;
        logic [9:0] d;
        r = {5'd0, x};
        for (int i = 4; i >= 0; i--) begin
            d = {5'd0, n} << i;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[3:0];
    endfunction

    // Saturating tick counter
    function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] t);
        return (t < TIMER_TOP) ? t + 1'b1 : t;
    endfunction

endpackage

// ===== sv/three_button_menu_controller.sv =====
// Three-button menu controller: debounced page, selection, volume, IR and LED control.
// A transaction is captured in the input register, processed combinationally and loaded into
// the output register that offers it; out_stall holds a full output and a full input register.
// Throughput: one tick per clock cycle while out_stall does not hold the output register.
// Reset (rst_n, asynchronous, active low) clears both pipeline valids and loads the
// default configuration and the power-up menu state.
`include "assert_macros.svh"

module three_button_menu_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  tbmc_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output tbmc_pkg::out_t                   out_data,
    input  logic                             cfg_write,
    input  logic [tbmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbmc_pkg::CFG_WIDTH-1:0]   cfg_data
);

    // Configuration registers
    logic [15:0] sample_period_reg;
    logic [15:0] return_hold_period_reg;
    logic [15:0] select_blink_period_reg;
    logic [15:0] page_blink_period_reg;
    logic [4:0]  ir_total_reg;

    // Pipeline registers
    logic           in_vld_reg;
    tbmc_pkg::in_t  in_data_reg;
    logic           out_vld_reg;
    tbmc_pkg::out_t out_data_reg;
    tbmc_pkg::out_t out_data_next;

    // Menu state
    tbmc_pkg::page_t                  page_reg, page_next;
    logic [2:0]                       item_sel_reg, item_sel_next;
    logic [6:0]                       volume_reg, volume_next;
    logic [3:0]                       ir_reg, ir_next;
    logic [2:0]                       bypass_reg, bypass_next;
    logic [2:0]                       button_prev_reg, button_prev_next;
    logic [tbmc_pkg::TIMER_BITS-1:0]  sample_timer_reg, sample_timer_next;
    logic [tbmc_pkg::TIMER_BITS-1:0]  lock_timer_reg, lock_timer_next;
    logic [3:0]                       blink_left_reg, blink_left_next;
    logic [tbmc_pkg::TIMER_BITS-1:0]  select_timer_reg, select_timer_next;
    logic [tbmc_pkg::TIMER_BITS-1:0]  page_timer_reg, page_timer_next;
    logic                             led_reg, led_next;

    logic advance;
    logic step_en;

    // Output register moves when empty or taken
    assign advance   = !out_vld_reg || !out_stall;
    assign step_en   = advance && in_vld_reg;
    assign in_stall  = in_vld_reg && !advance;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // One tick of menu processing
    always_comb
    begin
        logic [2:0] now_btn;
        logic [2:0] rise;
        logic [4:0] n;
        logic       redraw;
        logic       ir_chg;

        page_next         = page_reg;
        item_sel_next     = item_sel_reg;
        volume_next       = volume_reg;
        ir_next           = ir_reg;
        bypass_next       = bypass_reg;
        button_prev_next  = button_prev_reg;
        blink_left_next   = blink_left_reg;
        led_next          = led_reg;
        redraw            = 1'b0;
        ir_chg            = 1'b0;
        now_btn           = {in_data_reg.button_three, in_data_reg.button_two,
                             in_data_reg.button_one};
        rise              = now_btn & ~button_prev_reg;

        // Elapsed counters advance first
        sample_timer_next = tbmc_pkg::tick_up(sample_timer_reg);
        select_timer_next = tbmc_pkg::tick_up(select_timer_reg);
        page_timer_next   = tbmc_pkg::tick_up(page_timer_reg);
        lock_timer_next   = (lock_timer_reg != '0) ? lock_timer_reg - 1'b1 : lock_timer_reg;

        // Clamp IR count to 1..MAX_IR
        if (ir_total_reg == 5'd0)
        begin
            n = 5'd1;
        end
        else if (ir_total_reg > 5'(tbmc_pkg::MAX_IR))
        begin
            n = 5'(tbmc_pkg::MAX_IR);
        end
        else
        begin
            n = ir_total_reg;
        end

        // LED from the state held before this tick
        if (page_reg == tbmc_pkg::PAGE_MAIN)
        begin
            if (blink_left_reg != 4'd0)
            begin
                if (select_timer_next >= select_blink_period_reg)
                begin
                    select_timer_next = '0;
                    blink_left_next   = blink_left_reg - 4'd1;
                    led_next          = !led_reg;
                end
            end
            else
            begin
                led_next = 1'b0;
            end
        end
        else if (page_timer_next >= page_blink_period_reg)
        begin
            page_timer_next = '0;
            led_next        = !led_reg;
        end

        // Button sample, buttons act in the order three, one, two
        if (sample_timer_next >= sample_period_reg)
        begin
            sample_timer_next = '0;
            button_prev_next  = now_btn;

            if (rise[2])
            begin
                if (page_next == tbmc_pkg::PAGE_MAIN)
                begin
                    if (lock_timer_next == '0)
                    begin
                        if (item_sel_next == tbmc_pkg::SEL_VOLUME)
                        begin
                            page_next = tbmc_pkg::PAGE_VOLUME;
                        end
                        else if (item_sel_next == tbmc_pkg::SEL_IR)
                        begin
                            page_next = tbmc_pkg::PAGE_IR;
                        end
                    end
                end
                else
                begin
                    page_next       = tbmc_pkg::PAGE_MAIN;
                    lock_timer_next = return_hold_period_reg;
                end
                redraw = 1'b1;
            end

            if (rise[0])
            begin
                unique case (page_next)
                    tbmc_pkg::PAGE_MAIN:
                    begin
                        item_sel_next     = (item_sel_next >= tbmc_pkg::SEL_IR) ?
                                            tbmc_pkg::SEL_AMP : item_sel_next + 3'd1;
                        blink_left_next   = {item_sel_next + 3'd1, 1'b0};
                        select_timer_next = '0;
                        led_next          = 1'b0;
                        redraw            = 1'b1;
                    end
                    tbmc_pkg::PAGE_VOLUME:
                    begin
                        if (volume_next != 7'd0)
                        begin
                            volume_next = (volume_next >= tbmc_pkg::VOL_STEP) ?
                                          volume_next - tbmc_pkg::VOL_STEP : 7'd0;
                            redraw      = 1'b1;
                        end
                    end
                    default:
                    begin
                        ir_next = tbmc_pkg::ir_mod(5'(ir_next) + n - 5'd1, n);
                        ir_chg  = 1'b1;
                        redraw  = 1'b1;
                    end
                endcase
            end

            if (rise[1])
            begin
                unique case (page_next)
                    tbmc_pkg::PAGE_MAIN:
                    begin
                        if (item_sel_next < tbmc_pkg::SEL_VOLUME)
                        begin
                            bypass_next = bypass_next ^ (3'd1 << item_sel_next);
                            redraw      = 1'b1;
                        end
                    end
                    tbmc_pkg::PAGE_VOLUME:
                    begin
                        if (volume_next < tbmc_pkg::VOL_MAX)
                        begin
                            volume_next = (volume_next + tbmc_pkg::VOL_STEP > tbmc_pkg::VOL_MAX)
                                          ? tbmc_pkg::VOL_MAX
                                          : volume_next + tbmc_pkg::VOL_STEP;
                            redraw      = 1'b1;
                        end
                    end
                    default:
                    begin
                        ir_next = tbmc_pkg::ir_mod(5'(ir_next) + 5'd1, n);
                        ir_chg  = 1'b1;
                        redraw  = 1'b1;
                    end
                endcase
            end
        end

        // Result of this tick
        out_data_next.menu_page      = page_next;
        out_data_next.selected_item  = item_sel_next;
        out_data_next.volume_percent = volume_next;
        out_data_next.ir_index       = ir_next;
        out_data_next.ir_changed     = ir_chg;
        out_data_next.amp_bypass     = bypass_next[0];
        out_data_next.cab_bypass     = bypass_next[1];
        out_data_next.reverb_bypass  = bypass_next[2];
        out_data_next.led_lit        = led_next;
        out_data_next.redraw         = redraw;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Configuration registers; the preset indexes load the menu state below
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg       <= 16'd100;
            return_hold_period_reg  <= 16'd300;
            select_blink_period_reg <= 16'd150;
            page_blink_period_reg   <= 16'd250;
            ir_total_reg            <= 5'd13;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tbmc_pkg::CFG_SAMPLE_PERIOD:  sample_period_reg       <= cfg_data;
                tbmc_pkg::CFG_RETURN_HOLD:    return_hold_period_reg  <= cfg_data;
                tbmc_pkg::CFG_SELECT_BLINK:   select_blink_period_reg <= cfg_data;
                tbmc_pkg::CFG_PAGE_BLINK:     page_blink_period_reg   <= cfg_data;
                tbmc_pkg::CFG_IR_TOTAL:       ir_total_reg            <= cfg_data[4:0];
                default:                      ;
            endcase
        end
    end

    // Menu state; preset writes load the IR and bypass state directly
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg         <= tbmc_pkg::PAGE_MAIN;
            item_sel_reg     <= tbmc_pkg::SEL_CAB;
            volume_reg       <= tbmc_pkg::VOL_MAX;
            ir_reg           <= 4'd0;
            bypass_reg       <= 3'd1;
            button_prev_reg  <= 3'b111;
            sample_timer_reg <= '0;
            lock_timer_reg   <= '0;
            blink_left_reg   <= 4'd0;
            select_timer_reg <= '0;
            page_timer_reg   <= '0;
            led_reg          <= 1'b0;
        end
        else if (cfg_write && cfg_index == tbmc_pkg::CFG_INITIAL_IR)
        begin
            ir_reg <= cfg_data[3:0];
        end
        else if (cfg_write && cfg_index == tbmc_pkg::CFG_INITIAL_BYPASS)
        begin
            bypass_reg <= cfg_data[2:0];
        end
        else if (step_en)
        begin
            page_reg         <= page_next;
            item_sel_reg     <= item_sel_next;
            volume_reg       <= volume_next;
            ir_reg           <= ir_next;
            bypass_reg       <= bypass_next;
            button_prev_reg  <= button_prev_next;
            sample_timer_reg <= sample_timer_next;
            lock_timer_reg   <= lock_timer_next;
            blink_left_reg   <= blink_left_next;
            select_timer_reg <= select_timer_next;
            page_timer_reg   <= page_timer_next;
            led_reg          <= led_next;
        end
    end

    // Checks
    `ASSERT_CLK(a_ir_step_on_ir_page, clk, rst_n,
        out_valid && out_data.ir_changed |-> out_data.menu_page == tbmc_pkg::PAGE_IR,
        "IR step reported outside the IR page")
    `ASSERT_CLK(a_ir_step_redraws, clk, rst_n,
        out_valid && out_data.ir_changed |-> out_data.redraw,
        "IR step without redraw")
    `ASSERT_CLK(a_volume_limit, clk, rst_n,
        out_valid |-> out_data.volume_percent <= tbmc_pkg::VOL_MAX,
        "volume above limit")
    `ASSERT_ALWAYS(a_stall_needs_item, clk,
        in_stall |-> in_vld_reg,
        "input stalled with empty input register")

endmodule
